// ===== rtl/skx_pkg.sv =====
// Package: types, constants and functions for the SHA-256 counter keystream XOR unit.
`default_nettype none
package skx_pkg;

    localparam int KeyWidth = 64;
    localparam int KeyWords = 4;
    localparam int CfgIdxWidth = 2;
    localparam int RoundCount = 64;

    localparam logic [CfgIdxWidth-1:0] CfgKeyWord0 = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CfgKeyWord1 = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CfgKeyWord2 = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CfgKeyWord3 = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_FINAL,
        ST_OUT
    } skx_state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } skx_hash_ctl_t;

    localparam logic [255:0] InitialH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Byte i of a little-endian 64-bit word.
    function automatic logic [7:0] le_byte(input logic [63:0] w, input int i);
        return w[8*i +: 8];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/skx_round.sv =====
// SHA-256 compression: one round per cycle over a 16-word rolling schedule.
`default_nettype none
module skx_round
    import skx_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [511:0]  block_in,
    output skx_hash_ctl_t      ctl,
    output logic [255:0]       digest
);

    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [5:0]  round_reg;
    logic        busy_reg, done_reg;
    logic [31:0] t1, t2, s0, s1, w_new;

    always_comb begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        t1 = h_reg + (rotr(e_reg, 6) ^ rotr(e_reg, 11) ^ rotr(e_reg, 25))
             + ((e_reg & f_reg) ^ (~e_reg & g_reg)) + round_k(round_reg) + w_reg[0];
        t2 = (rotr(a_reg, 2) ^ rotr(a_reg, 13) ^ rotr(a_reg, 22))
             + ((a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg));
        for (int i = 0; i < 15; i++) begin
            w_next[i] = w_reg[i+1];
        end
        w_next[15] = w_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end else if (busy_reg) begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'(RoundCount - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            for (int i = 0; i < 16; i++) begin
                w_reg[i] <= block_in[511 - 32*i -: 32];
            end
            {a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg} <= InitialH;
        end else if (busy_reg) begin
            w_reg <= w_next;
            h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

    always_comb begin
        digest[255:224] = InitialH[255:224] + a_reg;
        digest[223:192] = InitialH[223:192] + b_reg;
        digest[191:160] = InitialH[191:160] + c_reg;
        digest[159:128] = InitialH[159:128] + d_reg;
        digest[127:96]  = InitialH[127:96]  + e_reg;
        digest[95:64]   = InitialH[95:64]   + f_reg;
        digest[63:32]   = InitialH[63:32]   + g_reg;
        digest[31:0]    = InitialH[31:0]    + h_reg;
    end

endmodule
`default_nettype wire

// ===== rtl/sha256_counter_keystream_xor_unit.sv =====
// Top level: SHA-256 counter-mode keystream XOR over a byte stream.
//   channel  dir  fields (low bit first)
//   s_axis   in   tdata: data_byte[7:0]; tuser: first_byte; tlast: last_byte
//   m_axis   out  tdata: result_byte[7:0]; tlast: result_last
//   cfg      in   cfg_wr_en, cfg_index (0..3 key words), cfg_data[63:0]
// A byte that reuses the held block is accepted, then presented from the result register.
// A byte that needs a new block goes through accept, load, 64 rounds of the shared
// round unit, final add and result.
// Reset clears counter, offset and block-valid flag; the block register is not reset.
// A stalled result holds m_axis_tdata; no new byte is taken until it is delivered.
`default_nettype none
module sha256_counter_keystream_xor_unit
    import skx_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // data_byte[7:0]
    input  wire logic                   s_axis_tuser,   // first_byte
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // result_byte[7:0]
    output logic                        m_axis_tlast,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CfgIdxWidth-1:0] cfg_index,
    input  wire logic [KeyWidth-1:0]    cfg_data
);

    skx_state_t    state_reg, state_next;
    logic [KeyWidth-1:0] key_reg [KeyWords];
    logic [63:0]   counter_reg;
    logic [4:0]    offset_reg;
    logic          valid_reg;
    logic [255:0]  block_reg;
    logic [7:0]    data_reg;
    logic          last_reg;
    logic          hash_start;
    logic          accept;
    logic [511:0]  msg;
    logic [255:0]  digest;
    skx_hash_ctl_t hctl;
    logic [7:0]    ks_byte;

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KeyWords; i++) key_reg[i] <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CfgKeyWord0: key_reg[0] <= cfg_data;
                CfgKeyWord1: key_reg[1] <= cfg_data;
                CfgKeyWord2: key_reg[2] <= cfg_data;
                CfgKeyWord3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        msg = '0;
        for (int i = 0; i < 32; i++) begin
            msg[511 - 8*i -: 8] = le_byte(key_reg[i/8], i%8);
        end
        for (int i = 0; i < 8; i++) begin
            msg[511 - 8*(32+i) -: 8] = le_byte(counter_reg, i);
        end
        msg[511 - 8*40 -: 8] = 8'h80;
        msg[15:0] = 16'h0140;
    end

    skx_round u_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (hash_start),
        .block_in (msg),
        .ctl      (hctl),
        .digest   (digest)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = (s_axis_tuser || !valid_reg) ? ST_HASH : ST_OUT;
            ST_HASH:  state_next = ST_FINAL;
            ST_FINAL: if (hctl.done) state_next = ST_OUT;
            ST_OUT:   if (m_axis_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (state_reg == ST_IDLE);
        m_axis_tvalid = (state_reg == ST_OUT);
        hash_start    = (state_reg == ST_HASH);
    end

    assign ks_byte = block_reg[255 - 8*offset_reg -: 8];
    assign m_axis_tdata = data_reg ^ ks_byte;
    assign m_axis_tlast = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            counter_reg <= '0;
            offset_reg  <= '0;
            valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && s_axis_tuser) begin
                counter_reg <= '0;
                offset_reg  <= '0;
                valid_reg   <= 1'b0;
            end
            if (hctl.done) begin
                counter_reg <= counter_reg + 64'd1;
                offset_reg  <= '0;
                valid_reg   <= 1'b1;
            end
            if (state_reg == ST_OUT && m_axis_tready) begin
                offset_reg <= offset_reg + 5'd1;
                if (offset_reg == 5'd31) valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
        if (hctl.done) block_reg <= digest;
    end

endmodule
`default_nettype wire

// ===== sim/tb_sha256_counter_keystream_xor_unit.sv =====
// Testbench: byte stream through the SHA-256 counter keystream XOR unit, checked by a predictor.
`timescale 1ns / 100ps
module tb_sha256_counter_keystream_xor_unit;
    import skx_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_wr_en = 1'b0;
    logic [CfgIdxWidth-1:0] cfg_index = '0;
    logic [KeyWidth-1:0] cfg_data = '0;

    sha256_counter_keystream_xor_unit DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct packed {
        logic [7:0] data;
        logic first;
        logic last;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic last;
    } xor_result_t;

    typedef struct {
        byte_item_t item;
        logic known;
        xor_result_t result;
    } stim_row_t;

    logic [63:0] key_shadow [KeyWords];
    logic [63:0] ks_counter;
    logic [4:0] ks_offset;
    logic [255:0] ks_block;
    logic ks_valid;

    xor_result_t expected_results[$];
    stim_row_t stim_rows[$];
    int errors = 0;
    int cycles = 0;
    bit stall_long = 1'b0;

    localparam logic [31:0] KTab [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Digest bytes in output order: byte 0 in bits 255:248.
    function automatic logic [255:0] keystream_digest(logic [63:0] ctr);
        logic [7:0] msg [64];
        logic [31:0] w [64];
        logic [31:0] h [8];
        logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
        logic [255:0] dig;
        for (int i = 0; i < 64; i++) msg[i] = 8'h00;
        for (int i = 0; i < 32; i++) msg[i] = key_shadow[i / 8][8 * (i % 8) +: 8];
        for (int i = 0; i < 8; i++) msg[32 + i] = ctr[8 * i +: 8];
        msg[40] = 8'h80;
        msg[62] = 8'h01;
        msg[63] = 8'h40;
        for (int i = 0; i < 16; i++)
            w[i] = {msg[4 * i], msg[4 * i + 1], msg[4 * i + 2], msg[4 * i + 3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
        for (int i = 0; i < 64; i++) begin
            t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + KTab[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        dig = {h[0] + a, h[1] + b, h[2] + c, h[3] + d, h[4] + e, h[5] + f, h[6] + g,
               h[7] + hh};
        return dig;
    endfunction

    function automatic xor_result_t predict_xor(byte_item_t it);
        xor_result_t r;
        if (it.first) begin
            ks_counter = '0;
            ks_offset = '0;
            ks_valid = 1'b0;
        end
        if (!ks_valid) begin
            ks_block = keystream_digest(ks_counter);
            ks_counter = ks_counter + 1;
            ks_offset = '0;
            ks_valid = 1'b1;
        end
        r.data = it.data ^ ks_block[255 - 8 * ks_offset -: 8];
        r.last = it.last;
        ks_offset = ks_offset + 1;
        if (ks_offset == 0) ks_valid = 1'b0;
        return r;
    endfunction

    task automatic write_key(logic [CfgIdxWidth-1:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        key_shadow[idx] = val;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic send_byte(byte_item_t it, logic known, xor_result_t want);
        xor_result_t p;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
              ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        p = predict_xor(it);
        if (known && p !== want)
            $display("%0t predictor: expected %h actual %h", $time, want, p);
        if (known) p = want;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= it.data;
        s_axis_tuser <= it.first;
        s_axis_tlast <= it.last;
        expected_results.push_back(p);
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    function automatic byte_item_t rand_item(logic first);
        byte_item_t it;
        it.data = 8'($urandom_range(0, 255));
        it.first = first;
        it.last = $urandom_range(0, 7) == 0;
        return it;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("tb_sha256_counter_keystream_xor_unit: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        xor_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected item: actual %h/%b", $time, m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata !== want.data) begin
                    $display("%0t result_byte: expected %h actual %h", $time, want.data,
                             m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t result_last: expected %b actual %b", $time, want.last,
                             m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        int n;
        if (stall_long) begin
            m_axis_tready <= 1'b0;
            repeat (400) @(negedge aclk);
            stall_long = 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
            repeat (n) @(negedge aclk);
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 60)) @(negedge aclk);
        end
    end

    initial begin
        byte_item_t it;
        xor_result_t none;
        stim_row_t row;
        logic [63:0] key_sets [4][4];
        int sent;
        none = '0;
        for (int k = 0; k < KeyWords; k++) key_shadow[k] = '0;
        ks_counter = '0;
        ks_offset = '0;
        ks_block = '0;
        ks_valid = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: zero key, extremes of data, flags, block boundary, restart.
        stim_rows.push_back('{'{8'h00, 1'b1, 1'b0}, 1'b0, none});
        stim_rows.push_back('{'{8'hff, 1'b0, 1'b0}, 1'b0, none});
        stim_rows.push_back('{'{8'h00, 1'b0, 1'b1}, 1'b0, none});
        for (int i = 0; i < 31; i++)
            stim_rows.push_back('{'{i[0] ? 8'hff : 8'h00, 1'b0, i == 30}, 1'b0, none});
        stim_rows.push_back('{'{8'h5a, 1'b1, 1'b1}, 1'b0, none});
        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            send_byte(row.item, row.known, row.result);
        end
        wait_drained();

        key_sets[0] = '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                        64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff};
        key_sets[1] = '{64'h0, 64'h0, 64'h0, 64'h0};
        for (int s = 2; s < 4; s++)
            for (int k = 0; k < 4; k++) key_sets[s][k] = {$urandom, $urandom};

        sent = 0;
        for (int s = 0; s < 4; s++) begin
            for (int k = 0; k < 4; k++) write_key(CfgIdxWidth'(k), key_sets[s][k]);
            if (s == 2) begin
                fork
                    begin
                        @(negedge aclk);
                        stall_long = 1'b1;
                    end
                join_none
            end
            while (sent < 162 * (s + 1)) begin
                int msg_len;
                msg_len = ($urandom_range(0, 4) == 0) ? $urandom_range(33, 100)
                                                      : $urandom_range(1, 40);
                for (int j = 0; j < msg_len; j++) begin
                    it = rand_item(j == 0 ? ($urandom_range(0, 9) != 0) : 1'b0);
                    if (j == msg_len - 1) it.last = 1'b1;
                    send_byte(it, 1'b0, none);
                    sent++;
                end
            end
            wait_drained();
        end
        if (errors == 0)
            $display("tb_sha256_counter_keystream_xor_unit: done, clean");
        else
            $display("tb_sha256_counter_keystream_xor_unit: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/skx_pkg.sv
rtl/skx_round.sv
rtl/sha256_counter_keystream_xor_unit.sv
sim/tb_sha256_counter_keystream_xor_unit.sv
